/* sv/swmf_pkg.sv */
`default_nettype none

package swmf_pkg;

    localparam int WINDOW   = 8;
    localparam int SAMPLE_W = 28;
    localparam int FILL_W   = 4;
    localparam int AGE_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IDX_W    = AGE_W;
    localparam int CNT_W    = $clog2(WINDOW + 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [AGE_W-1:0]           age_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [FILL_W-1:0]          fill_t;

    localparam age_t AGE_OLDEST = age_t'(WINDOW - 1);

    typedef struct packed {
        logic    valid;
        sample_t value;
        age_t    age;
    } entry_t;

    typedef struct packed {
        logic    en;
        logic    full;
        sample_t sample;
    } cell_ctrl_t;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam entry_t  ENTRY_HEAD = '{valid: 1'b1, value: SAMPLE_MIN, age: '0};
    localparam entry_t  ENTRY_TAIL = '{valid: 1'b0, value: '0, age: '0};

endpackage

`default_nettype wire

/* sv/sliding_window_median_filter.sv */
// Running median over the newest WINDOW signed samples.
// Input request: sample is taken at a rising edge with in_valid high and
// in_stall low. Every accepted request yields exactly one output request
// carrying median (element count/2 of the ascending window, the upper middle
// for an even count) and fill_level (samples held, 1 to WINDOW).
// The window lives in a row of cells kept in ascending order, each tagged
// with its age; a new sample is inserted and the oldest dropped in the same
// register update, so one request is accepted every cycle while in_stall is low.
// An accepted request updates the cell row and sets a pending flag; the result
// is registered onto median, fill_level and out_valid once the output side is free.
// Throughput: one request per cycle while the output side is not stalled.
// When out_stall is held, the output register and one pending result are
// kept; in_stall then rises and further samples wait. Output payload is
// held stable while stalled.
// Reset (rst_n low, asynchronous) empties the window and drops any pending
// or presented result; no clearing pass is needed afterwards.
`default_nettype none

module sliding_window_median_filter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_stall,
    input  wire swmf_pkg::sample_t sample,
    output      logic              out_valid,
    input  wire logic              out_stall,
    output      swmf_pkg::sample_t median,
    output      swmf_pkg::fill_t   fill_level
);
    import swmf_pkg::*;

    entry_t     cell_q [WINDOW];
    logic       drop_chain [WINDOW+1];
    cell_ctrl_t ctrl;

    cnt_t    count_reg;
    cnt_t    count_next;
    logic    pend_reg;
    logic    pend_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t median_reg;
    fill_t   fill_reg;
    logic    accept;
    logic    advance;
    logic    full;
    logic [IDX_W-1:0] med_idx;

    assign full    = (count_reg == cnt_t'(WINDOW));
    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = pend_reg && !advance;
    assign accept  = in_valid && !in_stall;

    assign ctrl = '{en: accept, full: full, sample: sample};
    assign drop_chain[0] = 1'b0;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;

        if (i == 0)
        begin : g_head
            assign left_e = ENTRY_HEAD;
        end
        else
        begin : g_mid_l
            assign left_e = cell_q[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_tail
            assign right_e = ENTRY_TAIL;
        end
        else
        begin : g_mid_r
            assign right_e = cell_q[i+1];
        end

        swmf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_e),
            .right     (right_e),
            .drop_left (drop_chain[i]),
            .drop_out  (drop_chain[i+1]),
            .entry     (cell_q[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && !full)
        begin
            count_next = count_reg + cnt_t'(1);
        end
    end

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = pend_reg;
            pend_next      = 1'b0;
        end
        if (accept)
        begin
            pend_next = 1'b1;
        end
    end

    assign med_idx = IDX_W'(count_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pend_reg)
        begin
            median_reg <= cell_q[med_idx].value;
            fill_reg   <= FILL_W'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign median     = median_reg;
    assign fill_level = fill_reg;

endmodule

`default_nettype wire

/* sv/swmf_cell.sv */
`default_nettype none

module swmf_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire swmf_pkg::cell_ctrl_t ctrl,
    input  wire swmf_pkg::entry_t    left,
    input  wire swmf_pkg::entry_t    right,
    input  wire logic                drop_left,
    output      logic                drop_out,
    output      swmf_pkg::entry_t    entry
);
    import swmf_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    entry_t k_cur;
    entry_t k_prev;
    logic   drop_self;
    logic   below_cur;
    logic   below_prev;

    // Removing the oldest entry closes the gap by taking the right neighbour;
    // the new sample then opens a slot by taking the left neighbour.
    always_comb
    begin
        drop_self  = ctrl.full && entry_reg.valid && (entry_reg.age == AGE_OLDEST);
        drop_out   = drop_left || drop_self;
        k_cur      = drop_out  ? right : entry_reg;
        k_prev     = drop_left ? entry_reg : left;
        below_cur  = k_cur.valid  && !($signed(k_cur.value)  > $signed(ctrl.sample));
        below_prev = k_prev.valid && !($signed(k_prev.value) > $signed(ctrl.sample));

        if (below_cur)
        begin
            entry_next     = k_cur;
            entry_next.age = k_cur.age + age_t'(1);
        end
        else if (below_prev)
        begin
            entry_next = '{valid: 1'b1, value: ctrl.sample, age: '0};
        end
        else
        begin
            entry_next     = k_prev;
            entry_next.age = k_prev.age + age_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (ctrl.en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

/* sv/swmf_checker.sv */
`default_nettype none

module swmf_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire swmf_pkg::sample_t median,
    input wire swmf_pkg::fill_t   fill_level
);
    import swmf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(median) && $stable(fill_level)))
        else $error("Stalled output request changed.");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_level != '0) && (fill_level <= FILL_W'(WINDOW)))
        else $error("Fill level out of range.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("Input stalled while the output side was free.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
        else $error("Accepted request produced no output request.");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 out_valid |-> (fill_level >= $past(fill_level)))
        else $error("Fill level fell between results.");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (.*);

`default_nettype wire

/* tb/sv/median_checker.sv */
`default_nettype none

module median_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire swmf_pkg::sample_t sample,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire swmf_pkg::sample_t median,
    input  wire swmf_pkg::fill_t   fill_level,
    output int                     failures,
    output int                     pending,
    output int                     results
);
    timeunit 1ns;
    timeprecision 1ps;
    import swmf_pkg::*;

    typedef struct packed {
        sample_t median;
        fill_t   fill;
    } median_result_t;

    median_result_t expected_medians[$];
    sample_t        held[WINDOW];
    int             held_count;

    function automatic sample_t window_median(input sample_t w[WINDOW], input int n);
        sample_t sorted[WINDOW];
        sample_t key;
        int      j;
        sorted = w;
        for (int i = 1; i < n; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[n/2];
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t checker: %s got %0d, expected %0d", $realtime, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        median_result_t want;
        if (!rst_n)
        begin
            held_count = 0;
            expected_medians.delete();
            failures = 0;
            results = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results++;
                if (expected_medians.size() == 0)
                    report("unexpected result, median", int'(median), 0);
                else
                begin
                    want = expected_medians.pop_front();
                    if (median !== want.median)
                        report("median", int'(median), int'(want.median));
                    if (fill_level !== want.fill)
                        report("fill_level", int'(fill_level), int'(want.fill));
                end
            end
            if (in_valid && !in_stall)
            begin
                // The oldest sample leaves once the window is full.
                if (held_count < WINDOW)
                begin
                    held[held_count] = sample;
                    held_count++;
                end
                else
                begin
                    for (int i = 0; i < WINDOW - 1; i++)
                        held[i] = held[i+1];
                    held[WINDOW-1] = sample;
                end
                want.median = window_median(held, held_count);
                want.fill = fill_t'(held_count);
                expected_medians.push_back(want);
            end
        end
        pending = expected_medians.size();
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import swmf_pkg::*;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam int      NOMINAL    = 108000000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    out_stall = 1'b0;
    sample_t sample = '0;
    logic    in_stall;
    logic    out_valid;
    sample_t median;
    fill_t   fill_level;
    int      failures;
    int      pending;
    int      results;

    int      samples_sent = 0;
    int      burst_left = 0;
    int      stall_mode = 0;
    int      stall_left = 0;
    int      drift = 0;

    always #5 clk = ~clk;

    sliding_window_median_filter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .median     (median),
        .fill_level (fill_level)
    );

    median_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .median     (median),
        .fill_level (fill_level),
        .failures   (failures),
        .pending    (pending),
        .results    (results)
    );

    // The receiver moves between free running, light, heavy and solid stalling.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(4, 60);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= 1'b1;
        endcase
    end

    task automatic send_sample(input sample_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0, 1: return sample_t'($urandom);
            2, 3, 4, 5: return sample_t'(int'($urandom_range(0, 2 * NOMINAL)) - NOMINAL);
            6, 7: return sample_t'(int'($urandom_range(0, 6)) - 3);
            8:
            begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MIN;
                    1: return SAMPLE_MAX;
                    2: return sample_t'(-NOMINAL);
                    default: return sample_t'(NOMINAL);
                endcase
            end
            default:
            begin
                drift = drift + int'($urandom_range(0, 200)) - 100;
                return sample_t'(drift);
            end
        endcase
    endfunction

    initial
    begin
        sample_t directed[$];
        directed = '{
            SAMPLE_MIN, SAMPLE_MAX, sample_t'(0), sample_t'(-1), sample_t'(1),
            sample_t'(-NOMINAL), sample_t'(NOMINAL), sample_t'(7), sample_t'(7),
            sample_t'(7), sample_t'(50), sample_t'(40), sample_t'(30), sample_t'(20),
            sample_t'(10), 28'sh5555555, 28'shAAAAAAA, SAMPLE_MIN, SAMPLE_MIN,
            SAMPLE_MAX, SAMPLE_MAX
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_sample(directed[i]);
        drain_results();
        for (int n = 0; n < 700; n++)
        begin
            if ($urandom_range(0, 99) == 0)
                drain_results();
            send_sample(random_sample());
        end
        drain_results();
        repeat (10) @(posedge clk);
        $display("summary: %0d samples sent and %0d medians checked, with the window",
                 samples_sent, results);
        $display("summary: filled from empty, then sliding under random gaps and stalls");
        if (failures == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
